// ===== rtl/core/masked_bilinear_elevation_sample_macros.svh =====
// assertion macros for the masked bilinear elevation sampler
// used by the port checker; no other dependencies
`ifndef MASKED_BILINEAR_ELEVATION_SAMPLE_MACROS_SVH
`define MASKED_BILINEAR_ELEVATION_SAMPLE_MACROS_SVH

// same-cycle implication, quiet during reset
`define MBES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbes check failed");

// next-cycle implication, quiet during reset
`define MBES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbes check failed");

// next-cycle implication, also checked across reset
`define MBES_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mbes check failed");

`endif

// ===== rtl/core/mbes_pkg.sv =====
// shared types and constants of the masked bilinear elevation sampler
// no dependencies
package mbes_pkg;

   localparam int DEF_FRAC_BITS = 16;
   localparam int SAMPLE_W      = 16;
   localparam int OUT_W         = 32;
   localparam int OUT_FRAC      = 16;
   localparam int NUM_TAPS      = 4;

   localparam logic signed [SAMPLE_W-1:0] RESET_VALID_LOW  = -16'sd16384;
   localparam logic signed [SAMPLE_W-1:0] RESET_VALID_HIGH = 16'sd16384;
   localparam logic [OUT_W-1:0]           NODATA_ELEV      = 32'h8000_0000;

   typedef enum logic [0:0] {
      CSR_VALID_LOW  = 1'b0,
      CSR_VALID_HIGH = 1'b1
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type [NUM_TAPS-1:0] sample_set_type;

   // byte swap of a big-endian sample word
   function automatic sample_type swap_bytes(input logic [SAMPLE_W-1:0] raw);
      return sample_type'({raw[7:0], raw[15:8]});
   endfunction

endpackage

// ===== rtl/core/mbes_front.sv =====
// front stages: byte swap, band check, fractions, then masked weights
// depends on mbes_pkg
module mbes_front import mbes_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [15:0]              frac_u,
   input  logic [15:0]              frac_v,
   input  logic [15:0]              ul_raw,
   input  logic [15:0]              ur_raw,
   input  logic [15:0]              ll_raw,
   input  logic [15:0]              lr_raw,
   input  logic                     has_lower_row,
   input  sample_type               valid_low,
   input  sample_type               valid_high,
   output logic                     out_valid,
   output sample_set_type           out_samp,
   output logic [NUM_TAPS-1:0][2*FRAC_BITS:0] out_wgt
);

   localparam int WW = 2*FRAC_BITS + 1;

   logic [FRAC_BITS-1:0] fu, fv;
   logic [FRAC_BITS:0]   iu, iv;
   sample_set_type       samp;
   logic [NUM_TAPS-1:0]  take;

   // stage 1 registers
   logic                 v1_ff, v1_in;
   logic [FRAC_BITS:0]   fu1_ff, fv1_ff, iu1_ff, iv1_ff;
   sample_set_type       s1_ff;
   logic [NUM_TAPS-1:0]  take1_ff;

   // stage 2 registers
   logic                 v2_ff, v2_in;
   sample_set_type       s2_ff;
   logic [NUM_TAPS-1:0][WW-1:0] w2_ff, w2_in;
   logic [NUM_TAPS-1:0][2*FRAC_BITS+1:0] prod;

   assign fu = FRAC_BITS'(frac_u);
   assign fv = FRAC_BITS'(frac_v);
   assign iu = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fu};
   assign iv = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fv};

   always_comb begin
      samp[0] = swap_bytes(ul_raw);
      samp[1] = swap_bytes(ur_raw);
      samp[2] = swap_bytes(ll_raw);
      samp[3] = swap_bytes(lr_raw);
      for (int k = 0; k < NUM_TAPS; k++) begin
         take[k] = (samp[k] >= valid_low) && (samp[k] <= valid_high);
      end
      take[2] = take[2] & has_lower_row;
      take[3] = take[3] & has_lower_row;
   end

   assign v1_in = in_valid;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // weights: upper left, upper right, lower left, lower right
   always_comb begin
      prod[0] = iu1_ff * iv1_ff;
      prod[1] = fu1_ff * iv1_ff;
      prod[2] = iu1_ff * fv1_ff;
      prod[3] = fu1_ff * fv1_ff;
      for (int k = 0; k < NUM_TAPS; k++) begin
         w2_in[k] = take1_ff[k] ? prod[k][WW-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fu1_ff   <= {1'b0, fu};
         fv1_ff   <= {1'b0, fv};
         iu1_ff   <= iu;
         iv1_ff   <= iv;
         s1_ff    <= samp;
         take1_ff <= take;
         s2_ff    <= s1_ff;
         w2_ff    <= w2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_samp  = s2_ff;
   assign out_wgt   = w2_ff;

endmodule

// ===== rtl/core/mbes_mac.sv =====
// weighted sum stages: products, sum, magnitude and divider seed
// depends on mbes_pkg
module mbes_mac import mbes_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  sample_set_type                    in_samp,
   input  logic [NUM_TAPS-1:0][2*FRAC_BITS:0] in_wgt,
   output logic                              out_valid,
   output logic                              out_neg,
   output logic                              out_nodata,
   output logic [2*FRAC_BITS:0]              out_rem,
   output logic [2*FRAC_BITS:0]              out_div,
   output logic [OUT_FRAC-1:0]               out_low
);

   localparam int WW = 2*FRAC_BITS + 1;
   localparam int PW = WW + SAMPLE_W + 1;
   localparam int AW = PW + 2;
   localparam int MW = 2*FRAC_BITS + SAMPLE_W;

   logic                                v3_ff, v4_ff, v5_ff;
   logic signed [NUM_TAPS-1:0][PW-1:0]  p3_ff, p3_in;
   logic [WW:0]                         a01_ff, a23_ff;
   logic signed [AW-1:0]                acc4_ff, acc4_in;
   logic [WW-1:0]                       adj4_ff;
   logic [AW-1:0]                       mag;
   logic                                neg5_ff, nd5_ff;
   logic [WW-1:0]                       rem5_ff, div5_ff;
   logic [OUT_FRAC-1:0]                 low5_ff;

   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         p3_in[k] = PW'($signed({1'b0, in_wgt[k]}) * in_samp[k]);
      end
   end

   assign acc4_in = AW'($signed(p3_ff[0])) + AW'($signed(p3_ff[1]))
                  + AW'($signed(p3_ff[2])) + AW'($signed(p3_ff[3]));

   assign mag = acc4_ff[AW-1] ? AW'(-acc4_ff) : AW'(acc4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff   <= p3_in;
         a01_ff  <= {1'b0, in_wgt[0]} + {1'b0, in_wgt[1]};
         a23_ff  <= {1'b0, in_wgt[2]} + {1'b0, in_wgt[3]};
         acc4_ff <= acc4_in;
         // total weight never exceeds one in Q1.2F
         adj4_ff <= WW'(a01_ff + a23_ff);
         neg5_ff <= acc4_ff[AW-1];
         nd5_ff  <= (adj4_ff == '0);
         rem5_ff <= WW'(mag[MW-1:OUT_FRAC]);
         div5_ff <= adj4_ff;
         low5_ff <= mag[OUT_FRAC-1:0];
      end
   end

   assign out_valid  = v5_ff;
   assign out_neg    = neg5_ff;
   assign out_nodata = nd5_ff;
   assign out_rem    = rem5_ff;
   assign out_div    = div5_ff;
   assign out_low    = low5_ff;

endmodule

// ===== rtl/core/mbes_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on mbes_pkg
module mbes_div import mbes_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic                   in_neg,
   input  logic                   in_nodata,
   input  logic [2*FRAC_BITS:0]   in_rem,
   input  logic [2*FRAC_BITS:0]   in_div,
   input  logic [OUT_FRAC-1:0]    in_low,
   output logic                   out_valid,
   output logic                   out_neg,
   output logic                   out_nodata,
   output logic [OUT_W-1:0]       out_quot
);

   localparam int RW = 2*FRAC_BITS + 1;
   localparam int NS = OUT_W;

   logic [NS:0]                 v_ff, neg_ff, nd_ff;
   logic [NS:0][RW-1:0]         rem_ff, div_ff;
   logic [NS:0][OUT_FRAC-1:0]   low_ff;
   logic [NS:0][OUT_W-1:0]      q_ff;

   assign v_ff[0]   = in_valid;
   assign neg_ff[0] = in_neg;
   assign nd_ff[0]  = in_nodata;
   assign rem_ff[0] = in_rem;
   assign div_ff[0] = in_div;
   assign low_ff[0] = in_low;
   assign q_ff[0]   = '0;

   for (genvar j = 0; j < NS; j++) begin : g_step
      logic [RW:0]   trial;
      logic          fits;
      logic [RW-1:0] rem_in;

      // shift in the next dividend bit, zero past the magnitude
      always_comb begin
         trial  = {rem_ff[j], low_ff[j][OUT_FRAC-1]};
         fits   = (trial >= {1'b0, div_ff[j]});
         rem_in = fits ? RW'(trial - {1'b0, div_ff[j]}) : RW'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[j+1] <= neg_ff[j];
            nd_ff[j+1]  <= nd_ff[j];
            rem_ff[j+1] <= rem_in;
            div_ff[j+1] <= div_ff[j];
            low_ff[j+1] <= {low_ff[j][OUT_FRAC-2:0], 1'b0};
            q_ff[j+1]   <= {q_ff[j][OUT_W-2:0], fits};
         end
      end
   end

   assign out_valid  = v_ff[NS];
   assign out_neg    = neg_ff[NS];
   assign out_nodata = nd_ff[NS];
   assign out_quot   = q_ff[NS];

endmodule

// ===== rtl/core/masked_bilinear_elevation_sample.sv =====
// masked bilinear elevation sampler, top level
// depends on mbes_pkg, mbes_front, mbes_mac, mbes_div
//
// usage
//   request channel: req_valid with fractions, four big-endian samples and
//   the lower row flag; a request is taken on a clock edge with req_valid
//   high and req_stall low
//   response channel: rsp_valid with rsp_elevation (signed Q16.16) and
//   rsp_no_data; taken on a clock edge with rsp_valid high, rsp_stall low
//   csr port: csr_write_en, csr_index, csr_write_data set the valid band;
//   write only while no request is in flight
//   latency: 38 cycles from request to response (2 front stages, 3 sum
//   stages, 32 divider stages, output register)
//   throughput: one request per cycle, set by the one-bit-per-stage divider
//   which is fully pipelined
//   reset: synchronous, clears every valid bit and loads the band
//   -16384 .. 16384
//   stall: while a response waits under rsp_stall the whole pipeline holds,
//   bubbles included, and req_stall is high until the response is taken
module masked_bilinear_elevation_sample import mbes_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [15:0]         req_frac_u,
   input  logic [15:0]         req_frac_v,
   input  logic [15:0]         req_upper_left_raw,
   input  logic [15:0]         req_upper_right_raw,
   input  logic [15:0]         req_lower_left_raw,
   input  logic [15:0]         req_lower_right_raw,
   input  logic                req_has_lower_row,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_elevation,
   output logic                rsp_no_data,
   // csr port
   input  logic                csr_write_en,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_write_data
);

   localparam int RW = 2*FRAC_BITS + 1;

   // band registers
   sample_type valid_low_ff, valid_high_ff;

   // pipeline advance: hold only when the output register is full and blocked
   logic en;

   logic                         f_valid;
   sample_set_type               f_samp;
   logic [NUM_TAPS-1:0][RW-1:0]  f_wgt;

   logic                         m_valid, m_neg, m_nodata;
   logic [RW-1:0]                m_rem, m_div;
   logic [OUT_FRAC-1:0]          m_low;

   logic                         d_valid, d_neg, d_nodata;
   logic [OUT_W-1:0]             d_quot;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]             rsp_elev_ff, rsp_elev_in;
   logic                         rsp_nd_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_low_ff  <= RESET_VALID_LOW;
         valid_high_ff <= RESET_VALID_HIGH;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_VALID_LOW:  valid_low_ff  <= sample_type'(csr_write_data);
            CSR_VALID_HIGH: valid_high_ff <= sample_type'(csr_write_data);
            default: ;
         endcase
      end
   end

   mbes_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .frac_u        (req_frac_u),
      .frac_v        (req_frac_v),
      .ul_raw        (req_upper_left_raw),
      .ur_raw        (req_upper_right_raw),
      .ll_raw        (req_lower_left_raw),
      .lr_raw        (req_lower_right_raw),
      .has_lower_row (req_has_lower_row),
      .valid_low     (valid_low_ff),
      .valid_high    (valid_high_ff),
      .out_valid     (f_valid),
      .out_samp      (f_samp),
      .out_wgt       (f_wgt)
   );

   mbes_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (f_valid),
      .in_samp    (f_samp),
      .in_wgt     (f_wgt),
      .out_valid  (m_valid),
      .out_neg    (m_neg),
      .out_nodata (m_nodata),
      .out_rem    (m_rem),
      .out_div    (m_div),
      .out_low    (m_low)
   );

   // quotient of |sum| * 2^16 / weight, at most 2^31 unless the weight is zero
   mbes_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (m_valid),
      .in_neg     (m_neg),
      .in_nodata  (m_nodata),
      .in_rem     (m_rem),
      .in_div     (m_div),
      .in_low     (m_low),
      .out_valid  (d_valid),
      .out_neg    (d_neg),
      .out_nodata (d_nodata),
      .out_quot   (d_quot)
   );

   // sign restore, no-data substitution
   assign rsp_valid_in = d_valid;
   assign rsp_elev_in  = d_nodata ? NODATA_ELEV : (d_neg ? (OUT_W'(0) - d_quot) : d_quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_elev_ff <= rsp_elev_in;
         rsp_nd_ff   <= d_nodata;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_elevation = $signed(rsp_elev_ff);
   assign rsp_no_data   = rsp_nd_ff;

endmodule

// ===== rtl/core/mbes_checker.sv =====
// port checker for the masked bilinear elevation sampler, bound to the top
// depends on masked_bilinear_elevation_sample_macros.svh
`include "masked_bilinear_elevation_sample_macros.svh"

module mbes_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [31:0]  rsp_elevation,
   input logic                rsp_no_data
);

   // a no-data response carries -32768.0
   `MBES_ASSERT_NOW(a_nodata_value, clock, reset, rsp_valid && rsp_no_data,
      rsp_elevation == 32'sh8000_0000)

   // a blocked response blocks new requests
   `MBES_ASSERT_NOW(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)

   // nothing comes out right after reset
   `MBES_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // a blocked response is not dropped
   `MBES_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind masked_bilinear_elevation_sample mbes_checker u_mbes_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_elevation (rsp_elevation),
   .rsp_no_data   (rsp_no_data)
);
